// ----- sv/a2b_pkg.sv -----
// Shared types, constants and codes for the AVCC to Annex B converter.
// Depends on nothing; the datapath, controller, core and bench import it.
package a2b_pkg;

    localparam int PARAM_BYTES = 48;
    localparam int PLEN_W = $clog2(PARAM_BYTES + 1);
    localparam int PADDR_W = $clog2(PARAM_BYTES);
    localparam logic [23:0] MAX_PACKET_BYTES = 24'hFFFFFF;
    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

    typedef enum logic [2:0] {
        ST_BYTE       = 3'd0,
        ST_PARAMS_OK  = 3'd1,
        ST_OVERRUN    = 3'd2,
        ST_STORE_FULL = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_UNIT_LONG  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        RP_HEADER    = 3'd0,
        RP_SPS_COUNT = 3'd1,
        RP_LEN_HI    = 3'd2,
        RP_LEN_LO    = 3'd3,
        RP_DATA      = 3'd4,
        RP_PPS_COUNT = 3'd5,
        RP_DONE      = 3'd6
    } rphase_t;

    typedef enum logic [1:0] {
        PP_PREFIX = 2'd0,
        PP_FIRST  = 2'd1,
        PP_DATA   = 2'd2
    } pphase_t;

    // Controller states; each emit state but CS_PARAMS sends one word per cycle unless stalled.
    typedef enum logic [2:0] {
        CS_IDLE   = 3'd0,
        CS_PARAMS = 3'd1,
        CS_START  = 3'd2,
        CS_BYTE   = 3'd3,
        CS_STAT1  = 3'd4,
        CS_STAT2  = 3'd5
    } cstate_t;

    // Plan computed by the datapath for one accepted word.
    typedef struct packed {
        logic        params;     // send stored parameter sets
        logic        start;      // send a start code
        logic        long_start; // four-byte start code
        logic        data;       // send the input byte
        logic        stat1;      // send first status word
        status_t     stat1_code;
        logic        stat2;      // send second status word
    } plan_t;

    typedef struct packed {
        logic load;              // latch input and update parse state
        logic rd_en;             // read one store entry
        logic [PADDR_W-1:0] rd_addr;
    } cmd_t;

endpackage

// ----- sv/a2b_if.sv -----
// Valid/ready channels carrying the input and result words.
// Depends on nothing.
interface a2b_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  data_byte;
    logic [23:0] bytes_left;
    modport source (output valid, opcode, data_byte, bytes_left, input ready);
    modport sink (input valid, opcode, data_byte, bytes_left, output ready);
endinterface

interface a2b_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic        end_of_run;
    modport source (output valid, out_byte, status, end_of_run, input ready);
    modport sink (input valid, out_byte, status, end_of_run, output ready);
endinterface

// ----- sv/avcc_to_annexb_converter_core.sv -----
// AVCC to Annex B converter top level: controller plus datapath.
// An accepted word is planned first, then its result words go out in turn
// (up to 53 for an IDR unit with a full store), each stored parameter-set
// byte read before it is sent; a length word that stores a start code holds
// off the next word until the start code is in the store.
// Reset (rst_n low, asynchronous) clears all parse state; store is unset.
module avcc_to_annexb_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    a2b_in_if.sink     in_ch,
    a2b_out_if.source  out_ch
);
    import a2b_pkg::*;

    plan_t plan;
    cmd_t cmd;
    logic [PLEN_W-1:0] param_len;
    logic [7:0] byte_hold;
    logic [7:0] rd_data;
    logic store_busy;

    a2b_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .opcode(in_ch.opcode), .data_byte(in_ch.data_byte),
        .bytes_left(in_ch.bytes_left),
        .cmd(cmd), .plan(plan), .param_len(param_len),
        .byte_hold(byte_hold), .rd_data(rd_data), .store_busy(store_busy)
    );

    a2b_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_byte(out_ch.out_byte), .out_status(out_ch.status),
        .out_end(out_ch.end_of_run),
        .plan(plan), .param_len(param_len), .byte_hold(byte_hold),
        .rd_data(rd_data), .store_busy(store_busy), .cmd(cmd)
    );
endmodule

// ----- sv/a2b_ram.sv -----
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module a2b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- sv/a2b_datapath.sv -----
// Parse state for records and packets, the parameter store and the plan
// of result words for each accepted word. Depends on a2b_pkg, a2b_ram.
module a2b_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     opcode,
    input  logic [7:0]               data_byte,
    input  logic [23:0]              bytes_left,
    input  a2b_pkg::cmd_t            cmd,
    output a2b_pkg::plan_t           plan,
    output logic [a2b_pkg::PLEN_W-1:0] param_len,
    output logic [7:0]               byte_hold,
    output logic [7:0]               rd_data,
    output logic                     store_busy
);
    import a2b_pkg::*;

    logic [PLEN_W-1:0] plen_reg, plen_next;
    rphase_t rphase_reg, rphase_next;
    logic [2:0] ridx_reg, ridx_next;
    logic [7:0] units_reg, units_next;
    logic [15:0] ulen_reg, ulen_next;
    logic pps_reg, pps_next, rfail_reg, rfail_next;
    pphase_t pphase_reg, pphase_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0] pcnt_reg, pcnt_next;
    logic [31:0] ubl_reg, ubl_next;
    logic first_reg, first_next, drop_reg, drop_next;
    logic [7:0] byte_reg;
    plan_t plan_reg, plan_next;

    logic we;
    logic [PADDR_W-1:0] waddr;
    logic [7:0] wdata;
    logic [2:0] hdr_cnt;

    logic [23:0] rem;
    logic [15:0] size16;
    logic [31:0] size32;
    logic [PLEN_W+16:0] need;
    logic [15:0] ulen_dec;
    logic [7:0] units_dec;

    assign rem = (bytes_left != 24'd0) ? bytes_left - 24'd1 : 24'd0;
    assign size16 = {ulen_reg[15:8], data_byte};
    assign size32 = {acc_reg[23:0], data_byte};
    assign need = {17'd0, plen_reg} + (PLEN_W + 17)'(4) + {{(PLEN_W+1){1'b0}}, size16};
    assign ulen_dec = ulen_reg - 16'd1;
    assign units_dec = units_reg - 8'd1;

    always_comb
    begin
        plen_next = plen_reg; rphase_next = rphase_reg; ridx_next = ridx_reg;
        units_next = units_reg; ulen_next = ulen_reg; pps_next = pps_reg;
        rfail_next = rfail_reg; pphase_next = pphase_reg; acc_next = acc_reg;
        pcnt_next = pcnt_reg; ubl_next = ubl_reg; first_next = first_reg;
        drop_next = drop_reg;
        plan_next = '0;
        plan_next.stat1_code = ST_BYTE;
        we = 1'b0; waddr = plen_reg[PADDR_W-1:0]; wdata = data_byte; hdr_cnt = 3'd0;
        if (!opcode)
        begin
            if (!rfail_reg)
            begin
                case (rphase_reg)
                    RP_HEADER:
                    begin
                        if (ridx_reg == 3'd0)
                        begin
                            plen_next = '0; pps_next = 1'b0;
                        end
                        if (ridx_reg >= 3'd4)
                        begin
                            ridx_next = 3'd0; rphase_next = RP_SPS_COUNT;
                        end
                        else
                        begin
                            ridx_next = ridx_reg + 3'd1;
                        end
                    end
                    RP_SPS_COUNT:
                    begin
                        units_next = {3'd0, data_byte[4:0]};
                        rphase_next = (data_byte[4:0] != 5'd0) ? RP_LEN_HI : RP_PPS_COUNT;
                    end
                    RP_LEN_HI:
                    begin
                        ulen_next = {data_byte, 8'd0}; rphase_next = RP_LEN_LO;
                    end
                    RP_LEN_LO:
                    begin
                        if (need > (PLEN_W + 17)'(PARAM_BYTES))
                        begin
                            plan_next.stat1 = 1'b1; plan_next.stat1_code = ST_STORE_FULL;
                        end
                        else if ({8'd0, size16} > rem)
                        begin
                            plan_next.stat1 = 1'b1; plan_next.stat1_code = ST_OVERRUN;
                        end
                        else
                        begin
                            // The start-code writer puts the start code into the store.
                            hdr_cnt = 3'd4;
                            plen_next = plen_reg + PLEN_W'(4);
                            ulen_next = size16;
                            if (size16 == 16'd0)
                            begin
                                units_next = units_dec;
                                rphase_next = (units_dec != 8'd0) ? RP_LEN_HI
                                            : (pps_reg ? RP_DONE : RP_PPS_COUNT);
                            end
                            else
                            begin
                                rphase_next = RP_DATA;
                            end
                        end
                    end
                    RP_DATA:
                    begin
                        if (plen_reg < PLEN_W'(PARAM_BYTES))
                        begin
                            we = 1'b1; plen_next = plen_reg + PLEN_W'(1);
                        end
                        ulen_next = ulen_dec;
                        if (ulen_dec == 16'd0)
                        begin
                            units_next = units_dec;
                            rphase_next = (units_dec != 8'd0) ? RP_LEN_HI
                                        : (pps_reg ? RP_DONE : RP_PPS_COUNT);
                        end
                    end
                    RP_PPS_COUNT:
                    begin
                        units_next = data_byte; pps_next = 1'b1;
                        rphase_next = (data_byte != 8'd0) ? RP_LEN_HI : RP_DONE;
                    end
                    default:
                    begin
                    end
                endcase
                if (plan_next.stat1)
                begin
                    rfail_next = 1'b1; plen_next = '0;
                end
            end
            if (bytes_left == 24'd1)
            begin
                if (!rfail_next)
                begin
                    if (plan_next.stat1)
                    begin
                        plan_next.stat2 = 1'b1;
                    end
                    else
                    begin
                        plan_next.stat1 = 1'b1;
                        plan_next.stat1_code = (rphase_next == RP_DONE) ? ST_PARAMS_OK
                                                                        : ST_OVERRUN;
                    end
                    if (rphase_next != RP_DONE)
                    begin
                        plen_next = '0;
                    end
                end
                rphase_next = RP_HEADER; ridx_next = 3'd0; units_next = 8'd0;
                ulen_next = 16'd0; pps_next = 1'b0; rfail_next = 1'b0;
            end
        end
        else
        begin
            if (!drop_reg)
            begin
                if (pphase_reg == PP_PREFIX)
                begin
                    acc_next = size32;
                    if (pcnt_reg == 2'd3)
                    begin
                        pcnt_next = 2'd0; acc_next = 32'd0;
                        if (size32 > {8'd0, rem} || size32 > {8'd0, MAX_PACKET_BYTES})
                        begin
                            plan_next.stat1 = 1'b1; plan_next.stat1_code = ST_UNIT_LONG;
                        end
                        else if (size32 == 32'd0)
                        begin
                            plan_next.start = 1'b1; plan_next.long_start = first_reg;
                            first_next = 1'b0;
                        end
                        else
                        begin
                            ubl_next = size32; pphase_next = PP_FIRST;
                        end
                    end
                    else
                    begin
                        pcnt_next = pcnt_reg + 2'd1;
                    end
                end
                else if (ubl_reg > {8'd0, bytes_left})
                begin
                    plan_next.stat1 = 1'b1; plan_next.stat1_code = ST_UNIT_LONG;
                end
                else
                begin
                    if (pphase_reg == PP_FIRST)
                    begin
                        plan_next.params = (data_byte[4:0] == NAL_TYPE_IDR)
                                           && (plen_reg != '0);
                        plan_next.start = 1'b1; plan_next.long_start = first_reg;
                        first_next = 1'b0;
                    end
                    plan_next.data = 1'b1;
                    ubl_next = ubl_reg - 32'd1;
                    pphase_next = (ubl_reg != 32'd1) ? PP_DATA : PP_PREFIX;
                end
                if (plan_next.stat1)
                begin
                    drop_next = 1'b1;
                end
            end
            if (bytes_left == 24'd1)
            begin
                if (!drop_next && pphase_next == PP_PREFIX && pcnt_next != 2'd0)
                begin
                    if (plan_next.stat1)
                    begin
                        plan_next.stat2 = 1'b1;
                    end
                    else
                    begin
                        plan_next.stat1 = 1'b1; plan_next.stat1_code = ST_TRUNCATED;
                    end
                end
                pphase_next = PP_PREFIX; acc_next = 32'd0; pcnt_next = 2'd0;
                ubl_next = 32'd0; first_next = 1'b1; drop_next = 1'b0;
            end
        end
    end

    // Start-code writer: the four prefix bytes of a stored unit land over
    // the following cycles while the controller sends the word's results.
    logic [2:0] sc_left_reg, sc_left_next;
    logic [PADDR_W-1:0] sc_addr_reg, sc_addr_next;
    logic ram_we;
    logic [PADDR_W-1:0] ram_waddr;
    logic [7:0] ram_wdata;

    always_comb
    begin
        sc_left_next = sc_left_reg; sc_addr_next = sc_addr_reg;
        ram_we = 1'b0; ram_waddr = sc_addr_reg; ram_wdata = 8'd0;
        if (sc_left_reg != 3'd0)
        begin
            ram_we = 1'b1;
            ram_wdata = (sc_left_reg == 3'd1) ? 8'd1 : 8'd0;
            sc_left_next = sc_left_reg - 3'd1;
            sc_addr_next = sc_addr_reg + PADDR_W'(1);
        end
        else if (cmd.load && we)
        begin
            ram_we = 1'b1; ram_waddr = waddr; ram_wdata = wdata;
        end
        if (cmd.load && hdr_cnt != 3'd0)
        begin
            sc_left_next = hdr_cnt; sc_addr_next = plen_reg[PADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0; rphase_reg <= RP_HEADER; ridx_reg <= 3'd0;
            units_reg <= 8'd0; ulen_reg <= 16'd0; pps_reg <= 1'b0;
            rfail_reg <= 1'b0; pphase_reg <= PP_PREFIX; acc_reg <= 32'd0;
            pcnt_reg <= 2'd0; ubl_reg <= 32'd0; first_reg <= 1'b1;
            drop_reg <= 1'b0; plan_reg <= '0; sc_left_reg <= 3'd0;
            sc_addr_reg <= '0;
        end
        else
        begin
            sc_left_reg <= sc_left_next; sc_addr_reg <= sc_addr_next;
            if (cmd.load)
            begin
                plen_reg <= plen_next; rphase_reg <= rphase_next;
                ridx_reg <= ridx_next; units_reg <= units_next;
                ulen_reg <= ulen_next; pps_reg <= pps_next;
                rfail_reg <= rfail_next; pphase_reg <= pphase_next;
                acc_reg <= acc_next; pcnt_reg <= pcnt_next; ubl_reg <= ubl_next;
                first_reg <= first_next; drop_reg <= drop_next;
                plan_reg <= plan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
        end
    end

    a2b_ram #(.WIDTH(8), .DEPTH(PARAM_BYTES)) u_store (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_data)
    );

    assign plan = plan_reg;
    assign param_len = plen_reg;
    assign byte_hold = byte_reg;
    // The next word waits until the start code is in the store.
    assign store_busy = (sc_left_reg != 3'd0);

    assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PLEN_W'(PARAM_BYTES))
        else $error("store length past capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        sc_left_reg <= 3'd4)
        else $error("start-code writer count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        plan_reg.params |-> plan_reg.start && plan_reg.data)
        else $error("parameter sets planned without a unit");
endmodule

// ----- sv/a2b_ctrl.sv -----
// Controller: accepts a word, then walks its plan, one result per cycle when not
// stalled or reading the store, through an output register. Depends on a2b_pkg.
module a2b_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic [2:0]                 out_status,
    output logic                       out_end,
    input  a2b_pkg::plan_t             plan,
    input  logic [a2b_pkg::PLEN_W-1:0] param_len,
    input  logic [7:0]                 byte_hold,
    input  logic [7:0]                 rd_data,
    input  logic                       store_busy,
    output a2b_pkg::cmd_t              cmd
);
    import a2b_pkg::*;

    cstate_t state_reg, state_next;
    logic [PLEN_W-1:0] idx_reg, idx_next;
    logic [1:0] sc_reg, sc_next;
    logic rd_pend_reg, rd_pend_next;
    logic ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic [2:0] os_reg, os_next;
    logic oe_reg, oe_next;
    logic emit;
    logic [7:0] e_byte;
    status_t e_stat;
    logic e_last;
    logic can_emit;

    assign can_emit = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE; idx_reg <= '0; sc_reg <= 2'd0;
            rd_pend_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; idx_reg <= idx_next; sc_reg <= sc_next;
            rd_pend_reg <= rd_pend_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next; os_reg <= os_next; oe_reg <= oe_next;
    end

    // Next state of the plan walk after the parameter phase.
    function automatic cstate_t after_params(plan_t p);
        return p.start ? CS_START : (p.data ? CS_BYTE : (p.stat1 ? CS_STAT1 : CS_IDLE));
    endfunction

    always_comb
    begin
        state_next = state_reg; idx_next = idx_reg; sc_next = sc_reg;
        rd_pend_next = 1'b0; cmd = '0;
        emit = 1'b0; e_byte = 8'd0; e_stat = ST_BYTE; e_last = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = !store_busy;
                if (in_valid && !store_busy)
                begin
                    cmd.load = 1'b1;
                    state_next = CS_PARAMS;
                end
            end
            CS_PARAMS:
            begin
                // Store bytes come out one read ahead of the emit.
                if (!plan.params)
                begin
                    sc_next = plan.long_start ? 2'd0 : 2'd1;
                    state_next = after_params(plan);
                end
                else if (!rd_pend_reg)
                begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = idx_reg[PADDR_W-1:0];
                    rd_pend_next = 1'b1;
                end
                else if (can_emit)
                begin
                    emit = 1'b1; e_byte = rd_data;
                    if (idx_reg + PLEN_W'(1) == param_len)
                    begin
                        idx_next = '0;
                        sc_next = plan.long_start ? 2'd0 : 2'd1;
                        state_next = CS_START;
                    end
                    else
                    begin
                        idx_next = idx_reg + PLEN_W'(1);
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                end
            end
            CS_START:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    e_byte = (sc_reg == 2'd3) ? 8'd1 : 8'd0;
                    if (sc_reg == 2'd3)
                    begin
                        e_last = !plan.data && !plan.stat1;
                        state_next = plan.data ? CS_BYTE : (plan.stat1 ? CS_STAT1 : CS_IDLE);
                    end
                    sc_next = sc_reg + 2'd1;
                end
            end
            CS_BYTE:
            begin
                if (can_emit)
                begin
                    emit = 1'b1; e_byte = byte_hold;
                    e_last = !plan.stat1;
                    state_next = plan.stat1 ? CS_STAT1 : CS_IDLE;
                end
            end
            CS_STAT1:
            begin
                if (can_emit)
                begin
                    emit = 1'b1; e_stat = plan.stat1_code;
                    e_last = !plan.stat2;
                    state_next = plan.stat2 ? CS_STAT2 : CS_IDLE;
                end
            end
            CS_STAT2:
            begin
                if (can_emit)
                begin
                    emit = 1'b1; e_stat = ST_OVERRUN; e_last = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        ov_next = ov_reg && !out_ready;
        ob_next = ob_reg; os_next = os_reg; oe_next = oe_reg;
        if (emit)
        begin
            ov_next = 1'b1; ob_next = e_byte; os_next = e_stat; oe_next = e_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign out_status = os_reg;
    assign out_end = oe_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!ov_reg || out_ready))
        else $error("result overwrote a waiting word");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == CS_PARAMS)
        else $error("accepted word did not start its plan");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_PARAMS && plan.params) |-> param_len != '0)
        else $error("parameter insertion with an empty store");
endmodule

// ----- tb/avcc_to_annexb_converter_core_tb.sv -----
// Self-checking bench for the AVCC to Annex B converter core: a directed table
// of words, then random records, packets and noise, checked against a predictor.
// Depends on a2b_pkg, the a2b_in_if/a2b_out_if interfaces and the core RTL.
module avcc_to_annexb_converter_core_tb;
    import a2b_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_GOAL = 420;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic [23:0] bytes_left;
    } word_t;

    typedef struct {
        logic [7:0] out_byte;
        status_t    status;
        logic       end_of_run;
    } annexb_t;

    // One directed row; want_check marks rows whose final status is typed in.
    typedef struct {
        word_t   w;
        bit      want_check;
        status_t want_status;
    } row_t;

    logic clk;
    logic rst_n;
    a2b_in_if in_ch();
    a2b_out_if out_ch();

    avcc_to_annexb_converter_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    word_t   words[$];
    row_t    rows[$];
    annexb_t annexb_pending[$];
    int      errors = 0;
    int      sent = 0;
    int      taken = 0;
    int      cycles = 0;
    bit      calm = 0;
    bit      hold_done = 0;
    int      hold_cnt = 0;

    // Predictor state.
    logic [7:0]  pset_mem[PARAM_BYTES];
    int          pset_len;
    rphase_t     rec_phase;
    logic [2:0]  rec_index;
    logic [7:0]  rec_units;
    logic [15:0] rec_len;
    bit          rec_pps_seen;
    bit          rec_failed;
    pphase_t     pkt_phase;
    logic [31:0] pkt_acc;
    logic [1:0]  pkt_nbytes;
    logic [31:0] pkt_unit_left;
    bit          pkt_first;
    bit          pkt_drop;

    task automatic report(input string what);
        errors++;
        $display("ERROR cycle %0d: %s", cycles, what);
    endtask

    task automatic emit(inout annexb_t q[$], input logic [7:0] b, input status_t s);
        annexb_t r;
        r.out_byte = b;
        r.status = s;
        r.end_of_run = 1'b0;
        q.push_back(r);
    endtask

    task automatic emit_start(inout annexb_t q[$]);
        if (pkt_first)
            emit(q, 8'h00, ST_BYTE);
        emit(q, 8'h00, ST_BYTE);
        emit(q, 8'h00, ST_BYTE);
        emit(q, 8'h01, ST_BYTE);
        pkt_first = 0;
    endtask

    function automatic void unit_finished();
        rec_units = rec_units - 8'd1;
        if (rec_units != 0)
            rec_phase = RP_LEN_HI;
        else
            rec_phase = rec_pps_seen ? RP_DONE : RP_PPS_COUNT;
    endfunction

    task automatic record_byte(inout annexb_t q[$], input logic [7:0] b, input logic [23:0] left);
        int rem;
        int size;
        status_t err;
        bit bad;
        rem = (left != 0) ? int'(left) - 1 : 0;
        bad = 0;
        err = ST_BYTE;
        if (!rec_failed) begin
            case (rec_phase)
                RP_HEADER: begin
                    if (rec_index == 0) begin
                        pset_len = 0;
                        rec_pps_seen = 0;
                    end
                    if (rec_index >= 4) begin
                        rec_index = 0;
                        rec_phase = RP_SPS_COUNT;
                    end
                    else
                        rec_index++;
                end
                RP_SPS_COUNT: begin
                    rec_units = {3'b0, b[4:0]};
                    rec_phase = (rec_units != 0) ? RP_LEN_HI : RP_PPS_COUNT;
                end
                RP_LEN_HI: begin
                    rec_len = {b, 8'h00};
                    rec_phase = RP_LEN_LO;
                end
                RP_LEN_LO: begin
                    size = int'(rec_len | b);
                    if (pset_len + 4 + size > PARAM_BYTES) begin
                        bad = 1;
                        err = ST_STORE_FULL;
                    end
                    else if (size > rem) begin
                        bad = 1;
                        err = ST_OVERRUN;
                    end
                    else begin
                        for (int i = 0; i < 4; i++) begin
                            pset_mem[pset_len] = (i == 3) ? 8'h01 : 8'h00;
                            pset_len++;
                        end
                        rec_len = size[15:0];
                        if (size == 0)
                            unit_finished();
                        else
                            rec_phase = RP_DATA;
                    end
                end
                RP_DATA: begin
                    if (pset_len < PARAM_BYTES) begin
                        pset_mem[pset_len] = b;
                        pset_len++;
                    end
                    rec_len = rec_len - 16'd1;
                    if (rec_len == 0)
                        unit_finished();
                end
                RP_PPS_COUNT: begin
                    rec_units = b;
                    rec_pps_seen = 1;
                    rec_phase = (rec_units != 0) ? RP_LEN_HI : RP_DONE;
                end
                default: ;
            endcase
            if (bad) begin
                rec_failed = 1;
                pset_len = 0;
                emit(q, 8'h00, err);
            end
        end
        if (left == 1) begin
            if (!rec_failed) begin
                if (rec_phase == RP_DONE)
                    emit(q, 8'h00, ST_PARAMS_OK);
                else begin
                    pset_len = 0;
                    emit(q, 8'h00, ST_OVERRUN);
                end
            end
            rec_phase = RP_HEADER;
            rec_index = 0;
            rec_units = 0;
            rec_len = 0;
            rec_pps_seen = 0;
            rec_failed = 0;
        end
    endtask

    task automatic packet_byte(inout annexb_t q[$], input logic [7:0] b, input logic [23:0] left);
        logic [31:0] rem;
        logic [31:0] size;
        bit bad;
        rem = (left != 0) ? {8'h0, left} - 32'd1 : 32'd0;
        bad = 0;
        if (!pkt_drop) begin
            if (pkt_phase == PP_PREFIX) begin
                pkt_acc = {pkt_acc[23:0], b};
                if (pkt_nbytes == 3) begin
                    size = pkt_acc;
                    pkt_nbytes = 0;
                    pkt_acc = 0;
                    if (size > rem || size > {8'h0, MAX_PACKET_BYTES})
                        bad = 1;
                    else if (size == 0)
                        emit_start(q);
                    else begin
                        pkt_unit_left = size;
                        pkt_phase = PP_FIRST;
                    end
                end
                else
                    pkt_nbytes++;
            end
            else if (pkt_unit_left > {8'h0, left})
                bad = 1;
            else begin
                if (pkt_phase == PP_FIRST) begin
                    // An IDR unit is preceded by whatever parameter sets are stored.
                    if (b[4:0] == NAL_TYPE_IDR)
                        for (int i = 0; i < pset_len; i++)
                            emit(q, pset_mem[i], ST_BYTE);
                    emit_start(q);
                end
                emit(q, b, ST_BYTE);
                pkt_unit_left--;
                pkt_phase = (pkt_unit_left != 0) ? PP_DATA : PP_PREFIX;
            end
            if (bad) begin
                pkt_drop = 1;
                emit(q, 8'h00, ST_UNIT_LONG);
            end
        end
        if (left == 1) begin
            if (!pkt_drop && pkt_phase == PP_PREFIX && pkt_nbytes != 0)
                emit(q, 8'h00, ST_TRUNCATED);
            pkt_phase = PP_PREFIX;
            pkt_acc = 0;
            pkt_nbytes = 0;
            pkt_unit_left = 0;
            pkt_first = 1;
            pkt_drop = 0;
        end
    endtask

    // Works out the words one input word causes and queues them.
    task automatic predict_annexb(input word_t w, output int n, output status_t last_st);
        annexb_t q[$];
        if (w.opcode == 1'b0)
            record_byte(q, w.data_byte, w.bytes_left);
        else
            packet_byte(q, w.data_byte, w.bytes_left);
        n = q.size();
        last_st = ST_BYTE;
        if (n > 0) begin
            q[n-1].end_of_run = 1'b1;
            last_st = q[n-1].status;
        end
        foreach (q[i])
            annexb_pending.push_back(q[i]);
    endtask

    task automatic push_run(input logic op, input logic [7:0] bq[$]);
        word_t w;
        foreach (bq[i]) begin
            w.opcode = op;
            w.data_byte = bq[i];
            w.bytes_left = 24'(bq.size() - i);
            words.push_back(w);
        end
    endtask

    task automatic add_unit(inout logic [7:0] bq[$], input bit wide_len, input int len);
        if (wide_len) begin
            bq.push_back(len[15:8]);
            bq.push_back(len[7:0]);
        end
        else begin
            bq.push_back(len[31:24]);
            bq.push_back(len[23:16]);
            bq.push_back(len[15:8]);
            bq.push_back(len[7:0]);
        end
    endtask

    task automatic gen_record(input bit broken);
        logic [7:0] bq[$];
        int cnt;
        int len;
        for (int i = 0; i < 5; i++)
            bq.push_back($urandom);
        for (int k = 0; k < 2; k++) begin
            cnt = $urandom_range(0, 2);
            if (k == 0)
                bq.push_back({3'($urandom), 5'(cnt)});
            else
                bq.push_back(8'(cnt));
            for (int u = 0; u < cnt; u++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
                add_unit(bq, 1, len);
                for (int j = 0; j < len; j++)
                    bq.push_back($urandom);
            end
        end
        for (int j = $urandom_range(0, 2); j > 0; j--)
            bq.push_back($urandom);
        if (broken)
            bq = bq[0:$urandom_range(0, bq.size() - 1)];
        push_run(1'b0, bq);
    endtask

    task automatic gen_packet(input bit broken);
        logic [7:0] bq[$];
        int len;
        int pos;
        for (int u = $urandom_range(1, 3); u > 0; u--) begin
            len = $urandom_range(0, 8);
            add_unit(bq, 0, len);
            for (int j = 0; j < len; j++) begin
                if (j == 0 && $urandom_range(0, 2) == 0)
                    bq.push_back({3'($urandom), NAL_TYPE_IDR});
                else
                    bq.push_back($urandom);
            end
        end
        if (broken) begin
            pos = $urandom_range(0, bq.size() - 1);
            if ($urandom_range(0, 1) == 0)
                bq = bq[0:pos];
            else
                bq[pos] = $urandom;
        end
        push_run(1'b1, bq);
    endtask

    task automatic gen_noise();
        word_t w;
        int cnt;
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++) begin
            w.opcode = $urandom;
            w.data_byte = $urandom;
            w.bytes_left = (i == cnt - 1) ? 24'd1 : 24'($urandom);
            words.push_back(w);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] b, input logic [23:0] left,
                           input bit chk, input status_t st);
        row_t r;
        r.w.opcode = op;
        r.w.data_byte = b;
        r.w.bytes_left = left;
        r.want_check = chk;
        r.want_status = st;
        rows.push_back(r);
    endtask

    initial
    begin
        clk = 0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        logic [7:0] rec_bytes[14];
        logic [7:0] pkt_bytes[10];
        int pick;
        rec_bytes = '{8'h01, 8'h64, 8'h00, 8'h1f, 8'hff, 8'he1, 8'h00, 8'h02,
                      8'h67, 8'haa, 8'h01, 8'h00, 8'h01, 8'h68};
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'h88,
                      8'h00, 8'h00, 8'h00, 8'h00};
        foreach (rec_bytes[i])
            add_row(1'b0, rec_bytes[i], 24'(14 - i), i == 13, ST_PARAMS_OK);
        // IDR unit then an empty unit, which gets only a short start code.
        foreach (pkt_bytes[i])
            add_row(1'b1, pkt_bytes[i], 24'(10 - i), 0, ST_BYTE);
        add_row(1'b1, 8'hff, 24'hffffff, 0, ST_BYTE);
        add_row(1'b1, 8'h00, 24'd1, 1, ST_TRUNCATED);
        foreach (rows[i])
            words.push_back(rows[i].w);
        while (words.size() < rows.size() + ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                gen_record(0);
            else if (pick < 40)
                gen_record(1);
            else if (pick < 78)
                gen_packet(0);
            else if (pick < 90)
                gen_packet(1);
            else
                gen_noise();
        end
    end

    // Input side: drive, and predict on every accepted word.
    initial
    begin
        int n;
        status_t last_st;
        bit waiting;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.opcode = 0;
        in_ch.data_byte = 0;
        in_ch.bytes_left = 0;
        rec_phase = RP_HEADER;
        rec_index = 0;
        rec_units = 0;
        rec_len = 0;
        rec_pps_seen = 0;
        rec_failed = 0;
        pset_len = 0;
        pkt_phase = PP_PREFIX;
        pkt_acc = 0;
        pkt_nbytes = 0;
        pkt_unit_left = 0;
        pkt_first = 1;
        pkt_drop = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1;
        forever
        begin
            @(posedge clk);
            // A word once offered stays offered until it is taken.
            waiting = in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                predict_annexb(words[sent], n, last_st);
                if (sent < rows.size() && rows[sent].want_check && last_st != rows[sent].want_status)
                    report($sformatf("row %0d final status %0d, table says %0d",
                                     sent, last_st, rows[sent].want_status));
                sent++;
            end
            calm = (sent >= 150 && sent < 260);
            if (sent < words.size() && (waiting || calm || $urandom_range(0, 99) >= 19)) begin
                in_ch.valid <= 1;
                in_ch.opcode <= words[sent].opcode;
                in_ch.data_byte <= words[sent].data_byte;
                in_ch.bytes_left <= words[sent].bytes_left;
            end
            else
                in_ch.valid <= 0;
        end
    end

    // Output side: random stalls plus one long hold so the core backs up.
    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= 60) begin
                hold_done = 1;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge clk)
    begin
        annexb_t e;
        if (out_ch.valid && out_ch.ready) begin
            taken++;
            if (annexb_pending.size() == 0)
                report($sformatf("unexpected word byte %h status %0d", out_ch.out_byte,
                                 out_ch.status));
            else begin
                e = annexb_pending.pop_front();
                if (out_ch.out_byte !== e.out_byte)
                    report($sformatf("word %0d byte %h, predicted %h", taken,
                                     out_ch.out_byte, e.out_byte));
                if (out_ch.status !== e.status)
                    report($sformatf("word %0d status %0d, predicted %0d", taken,
                                     out_ch.status, e.status));
                if (out_ch.end_of_run !== e.end_of_run)
                    report($sformatf("word %0d end_of_run %b, predicted %b", taken,
                                     out_ch.end_of_run, e.end_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("avcc_to_annexb_converter_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1 && words.size() > 0);
        wait (sent == words.size());
        wait (annexb_pending.size() == 0);
        repeat (120)
            @(posedge clk);
        if (errors == 0 && annexb_pending.size() == 0)
            $display("avcc_to_annexb_converter_core: match");
        else
            $display("avcc_to_annexb_converter_core: mismatch");
        $finish;
    end

endmodule

// ----- avcc_to_annexb_converter_core.f -----
sv/a2b_pkg.sv
sv/a2b_if.sv
sv/a2b_ram.sv
sv/a2b_datapath.sv
sv/a2b_ctrl.sv
sv/avcc_to_annexb_converter_core.sv
tb/avcc_to_annexb_converter_core_tb.sv
